// ----- sv/relative_offset_byte_search_defines.svh -----
// Assertion macros for the relative offset byte search block.
// Users name clk and rst_n in scope; no other dependencies.
`ifndef RELATIVE_OFFSET_BYTE_SEARCH_DEFINES_SVH
`define RELATIVE_OFFSET_BYTE_SEARCH_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define ROSB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define ROSB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/rosb_pkg.sv -----
// Shared constants, register codes and word types for the byte search block.
// No dependencies.
`timescale 1ns / 1ps

package rosb_pkg;

    localparam int MAX_NEEDLE_DEF = 16;
    localparam int COUNT_BITS_DEF = 32;

    localparam int BYTE_W       = 8;
    localparam int NEEDLE_SLOTS = 16;
    localparam int NLEN_W       = 5;
    localparam int CFG_W        = 64;
    localparam int CFG_IDX_W    = 2;
    localparam int OUT_CNT_W    = 32;

    localparam logic [BYTE_W-1:0] SHIFT_LIMIT = 8'hff;
    localparam logic [NLEN_W-1:0] NLEN_RESET  = 5'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NEEDLE_LOW  = 2'd0,
        CFG_NEEDLE_HIGH = 2'd1,
        CFG_NEEDLE_LEN  = 2'd2
    } cfg_reg_t;

    typedef logic [NEEDLE_SLOTS-1:0][BYTE_W-1:0] needle_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
    } in_word_t;

    typedef struct packed {
        logic                 found;
        logic [BYTE_W-1:0]    shift_amount;
        logic [OUT_CNT_W-1:0] start_position;
        logic [OUT_CNT_W-1:0] match_total;
    } out_word_t;

endpackage

// ----- sv/rosb_stream_if.sv -----
// Valid/ready stream channel carrying one word of a given payload type.
// Payload types come from rosb_pkg at the point of instantiation.
`timescale 1ns / 1ps

interface rosb_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- sv/rosb_window.sv -----
// Input stage: byte history shift register, stream byte counter and stage valid.
// Depends on rosb_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "relative_offset_byte_search_defines.svh"

module rosb_window #(
    parameter int MAX_NEEDLE = rosb_pkg::MAX_NEEDLE_DEF,
    parameter int COUNT_BITS = rosb_pkg::COUNT_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  accept,
    input  logic [rosb_pkg::BYTE_W-1:0]           data_byte,
    input  logic                                  take,
    output logic [MAX_NEEDLE-1:0][rosb_pkg::BYTE_W-1:0] window,
    output logic [COUNT_BITS-1:0]                 seen,
    output logic                                  stage_valid
);
    import rosb_pkg::*;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    logic [MAX_NEEDLE-1:0][BYTE_W-1:0] win_reg, win_next;
    logic [COUNT_BITS-1:0]             seen_reg;
    logic [COUNT_BITS-1:0]             count_reg, count_next;
    logic                              valid_reg, valid_next;

    // Newest byte sits at index 0.
    always_comb
    begin
        win_next[0] = data_byte;
        for (int i = 1; i < MAX_NEEDLE; i++)
        begin
            win_next[i] = win_reg[i-1];
        end
    end

    assign count_next = (count_reg != CNT_MAX) ? count_reg + COUNT_BITS'(1) : count_reg;

    always_comb
    begin
        priority if (accept)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg   <= '0;
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (accept)
            begin
                win_reg   <= win_next;
                count_reg <= count_next;
            end
        end
    end

    // Snapshot of the stream index of the byte just taken.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            seen_reg <= count_reg;
        end
    end

    assign window      = win_reg;
    assign seen        = seen_reg;
    assign stage_valid = valid_reg;

    `ROSB_ASSERT_NOW(a_no_overwrite, valid_reg && !take, !accept,
        "input stage overwritten while holding a word")
    `ROSB_ASSERT_NEXT(a_count_tracks, accept && count_reg != CNT_MAX,
        count_reg == seen_reg + COUNT_BITS'(1),
        "byte counter out of step with stage snapshot")

endmodule

// ----- sv/rosb_match.sv -----
// Offset compare across the needle and result register with the match counter.
// Depends on rosb_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "relative_offset_byte_search_defines.svh"

module rosb_match #(
    parameter int MAX_NEEDLE = rosb_pkg::MAX_NEEDLE_DEF,
    parameter int COUNT_BITS = rosb_pkg::COUNT_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  stage_valid,
    input  logic [MAX_NEEDLE-1:0][rosb_pkg::BYTE_W-1:0] window,
    input  logic [COUNT_BITS-1:0]                 seen,
    input  rosb_pkg::needle_t                     needle,
    input  logic [rosb_pkg::NLEN_W-1:0]           needle_length,
    input  logic                                  out_ready,
    output logic                                  take,
    output logic                                  out_valid,
    output rosb_pkg::out_word_t                   result
);
    import rosb_pkg::*;

    localparam int LEN_W = $clog2(MAX_NEEDLE + 1);
    localparam int IDX_W = (MAX_NEEDLE > 1) ? $clog2(MAX_NEEDLE) : 1;
    localparam logic [NLEN_W-1:0]     MAX_LEN = NLEN_W'(MAX_NEEDLE);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    logic [LEN_W-1:0]                  len_eff;
    logic [LEN_W-1:0]                  len_m1;
    logic [MAX_NEEDLE-1:0][BYTE_W-1:0] diff;
    logic [MAX_NEEDLE-1:0]             agree;
    logic                              found_c;
    logic [COUNT_BITS-1:0]             start_c;
    logic [OUT_CNT_W-1:0]              start_out;
    logic [OUT_CNT_W-1:0]              total_out;

    logic                              valid_reg;
    logic                              found_reg;
    logic [BYTE_W-1:0]                 shift_reg;
    logic [OUT_CNT_W-1:0]              start_reg;
    logic [COUNT_BITS-1:0]             match_reg, match_next;

    assign len_eff = LEN_W'((needle_length > MAX_LEN) ? MAX_LEN : needle_length);
    assign len_m1  = len_eff - LEN_W'(1);

    // Needle byte k pairs with history byte len-1-k; all pairs compare at once.
    always_comb
    begin
        logic [LEN_W-1:0] pos;
        for (int k = 0; k < MAX_NEEDLE; k++)
        begin
            pos     = len_m1 - LEN_W'(k);
            diff[k] = needle[k] - window[pos[IDX_W-1:0]];
        end
        for (int k = 0; k < MAX_NEEDLE; k++)
        begin
            agree[k] = (LEN_W'(k) >= len_eff) || (diff[k] == diff[0]);
        end
    end

    assign found_c = (len_eff != '0) && (seen >= COUNT_BITS'(len_m1))
                  && (diff[0] != SHIFT_LIMIT) && (&agree);
    assign start_c = seen - COUNT_BITS'(len_m1);

    generate
        if (COUNT_BITS >= OUT_CNT_W)
        begin : g_wide
            assign start_out = start_c[OUT_CNT_W-1:0];
            assign total_out = match_reg[OUT_CNT_W-1:0];
        end
        else
        begin : g_narrow
            assign start_out = {{(OUT_CNT_W-COUNT_BITS){1'b0}}, start_c};
            assign total_out = {{(OUT_CNT_W-COUNT_BITS){1'b0}}, match_reg};
        end
    endgenerate

    assign take       = stage_valid && (!valid_reg || out_ready);
    assign match_next = (found_c && match_reg != CNT_MAX) ? match_reg + COUNT_BITS'(1)
                                                          : match_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= '0;
        end
        else
        begin
            if (take)
            begin
                valid_reg <= 1'b1;
                match_reg <= match_next;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Offset and start read zero on a miss.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            found_reg <= found_c;
            shift_reg <= found_c ? diff[0] : '0;
            start_reg <= found_c ? start_out : '0;
        end
    end

    assign out_valid             = valid_reg;
    assign result.found          = found_reg;
    assign result.shift_amount   = shift_reg;
    assign result.start_position = start_reg;
    assign result.match_total    = total_out;

    `ROSB_ASSERT_NOW(a_offset_range, valid_reg && found_reg, shift_reg != SHIFT_LIMIT,
        "match reported with excluded offset")
    `ROSB_ASSERT_NOW(a_miss_zero, valid_reg && !found_reg,
        shift_reg == '0 && start_reg == '0,
        "miss carries nonzero offset or start")
    `ROSB_ASSERT_NEXT(a_total_step, take && found_c && match_reg != CNT_MAX,
        match_reg == $past(match_reg) + COUNT_BITS'(1),
        "match counter did not advance on a hit")
    `ROSB_ASSERT_NEXT(a_total_hold, !take, $stable(match_reg),
        "match counter moved without a new result")

endmodule

// ----- sv/relative_offset_byte_search.sv -----
// Relative offset byte search.
// Stream bytes arrive one per word on data_ch (valid/ready). For each byte the
// block checks the window of needle_length bytes ending at it: it matches when
// one offset d in 0..254 makes (window byte k + d) mod 256 equal needle byte k
// for every k. Each byte yields exactly one word on result_ch: found, the
// offset, the stream index of the window start, and the running match count.
// Windows that would start before the first byte are not checked.
// Needle bytes and length are set through the cfg write port while idle.
// Each accepted byte passes through the history register, then the result register.
// Throughput: one byte per cycle while result_ch does not stall; the compare of all
// needle places runs in parallel between the history register and the result register.
// Reset clears the byte history, both counters, the needle (to zero) and
// sets needle length to one. When result_ch stalls, the result holds and one
// more byte is taken into the input stage; data_ch.ready then drops until the
// result is taken.
// Depends on rosb_pkg, rosb_stream_if, rosb_window and rosb_match.
`timescale 1ns / 1ps

module relative_offset_byte_search #(
    parameter int MAX_NEEDLE = rosb_pkg::MAX_NEEDLE_DEF,
    parameter int COUNT_BITS = rosb_pkg::COUNT_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    rosb_stream_if.sink                      data_ch,
    rosb_stream_if.source                    result_ch,
    input  logic                             cfg_we,
    input  logic [rosb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rosb_pkg::CFG_W-1:0]       cfg_data
);
    import rosb_pkg::*;

    logic [CFG_W-1:0]  needle_low_reg;
    logic [CFG_W-1:0]  needle_high_reg;
    logic [NLEN_W-1:0] pattern_len_reg;
    needle_t           needle;

    logic                              accept;
    logic                              take;
    logic                              stage_valid;
    logic [MAX_NEEDLE-1:0][BYTE_W-1:0] window;
    logic [COUNT_BITS-1:0]             seen;
    in_word_t                          in_word;
    out_word_t                         out_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            needle_low_reg  <= '0;
            needle_high_reg <= '0;
            pattern_len_reg <= NLEN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_NEEDLE_LOW:  needle_low_reg  <= cfg_data;
                CFG_NEEDLE_HIGH: needle_high_reg <= cfg_data;
                CFG_NEEDLE_LEN:  pattern_len_reg <= cfg_data[NLEN_W-1:0];
                default:         ;
            endcase
        end
    end

    assign needle = {needle_high_reg, needle_low_reg};

    assign in_word       = data_ch.payload;
    assign data_ch.ready = !stage_valid || take;
    assign accept        = data_ch.valid && data_ch.ready;

    rosb_window #(
        .MAX_NEEDLE (MAX_NEEDLE),
        .COUNT_BITS (COUNT_BITS)
    ) u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .data_byte   (in_word.data_byte),
        .take        (take),
        .window      (window),
        .seen        (seen),
        .stage_valid (stage_valid)
    );

    rosb_match #(
        .MAX_NEEDLE (MAX_NEEDLE),
        .COUNT_BITS (COUNT_BITS)
    ) u_match (
        .clk           (clk),
        .rst_n         (rst_n),
        .stage_valid   (stage_valid),
        .window        (window),
        .seen          (seen),
        .needle        (needle),
        .needle_length (pattern_len_reg),
        .out_ready     (result_ch.ready),
        .take          (take),
        .out_valid     (result_ch.valid),
        .result        (out_word)
    );

    assign result_ch.payload = out_word;

endmodule

// ----- test/rosb_match_checker.sv -----
// Checker for the relative offset byte search block: watches the byte and result
// channels and the config port, forecasts every result and compares it on arrival.
// Depends on rosb_pkg.
`timescale 1ns / 1ps

module rosb_match_checker
    import rosb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_valid,
    input  logic                 byte_ready,
    input  in_word_t             byte_word,
    input  logic                 result_valid,
    input  logic                 result_ready,
    input  out_word_t            result_word,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int unsigned          outstanding,
    output int unsigned          fail_total
);

    localparam logic [OUT_CNT_W-1:0] COUNT_MAX = '1;
    localparam int unsigned          PRINT_CAP = 40;

    needle_t                             needle;
    logic [NLEN_W-1:0]                   pattern_len;
    logic [NEEDLE_SLOTS-1:0][BYTE_W-1:0] history;
    logic [OUT_CNT_W-1:0]                bytes_seen;
    logic [OUT_CNT_W-1:0]                matches_seen;
    int unsigned                         results_taken;
    out_word_t                           pending_matches[$];

    task automatic report(input string msg);
        if (fail_total < PRINT_CAP)
            $display("MISMATCH at result %0d: %s", results_taken, msg);
        fail_total++;
    endtask

    // Take one stream byte, advance history and counters, return its result word.
    function automatic out_word_t compute_window_match(input logic [BYTE_W-1:0] fresh);
        out_word_t         res;
        int                span;
        logic [BYTE_W-1:0] offset;
        logic              hit;
        span = (pattern_len > MAX_NEEDLE_DEF) ? MAX_NEEDLE_DEF : int'(pattern_len);
        history = {history[NEEDLE_SLOTS-2:0], fresh};
        hit = 1'b0;
        offset = '0;
        // window byte k sits at history[span-1-k]; skip windows reaching before byte 0
        if (span > 0 && bytes_seen >= OUT_CNT_W'(span - 1))
        begin
            offset = needle[0] - history[span-1];
            hit = (offset != SHIFT_LIMIT);
            for (int k = 1; k < span; k++)
                if (BYTE_W'(needle[k] - history[span-1-k]) != offset)
                    hit = 1'b0;
        end
        res.found          = hit;
        res.shift_amount   = hit ? offset : '0;
        res.start_position = hit ? bytes_seen - OUT_CNT_W'(span - 1) : '0;
        if (hit && matches_seen != COUNT_MAX)
            matches_seen++;
        if (bytes_seen != COUNT_MAX)
            bytes_seen++;
        res.match_total = matches_seen;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_word_t want;
        if (!rst_n)
        begin
            needle        = '0;
            pattern_len   = NLEN_RESET;
            history       = '0;
            bytes_seen    = '0;
            matches_seen  = '0;
            results_taken = 0;
            fail_total    = 0;
            pending_matches.delete();
            outstanding  <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    CFG_NEEDLE_LOW:  needle[7:0]  = cfg_data;
                    CFG_NEEDLE_HIGH: needle[15:8] = cfg_data;
                    CFG_NEEDLE_LEN:  pattern_len  = cfg_data[NLEN_W-1:0];
                    default: ;
                endcase
            end
            if (byte_valid && byte_ready)
                pending_matches.push_back(compute_window_match(byte_word.data_byte));
            if (result_valid && result_ready)
            begin
                if (pending_matches.size() == 0)
                    report("result word with nothing pending");
                else
                begin
                    want = pending_matches.pop_front();
                    if (result_word.found !== want.found)
                        report($sformatf("found got %0b want %0b",
                                         result_word.found, want.found));
                    if (result_word.shift_amount !== want.shift_amount)
                        report($sformatf("shift_amount got %0d want %0d",
                                         result_word.shift_amount, want.shift_amount));
                    if (result_word.start_position !== want.start_position)
                        report($sformatf("start_position got %0d want %0d",
                                         result_word.start_position, want.start_position));
                    if (result_word.match_total !== want.match_total)
                        report($sformatf("match_total got %0d want %0d",
                                         result_word.match_total, want.match_total));
                end
                results_taken++;
            end
            outstanding <= pending_matches.size();
        end
    end

endmodule

// ----- test/tb_relative_offset_byte_search.sv -----
// Testbench top for relative_offset_byte_search: drives bytes and needle settings,
// stalls both channels at random and gives the verdict from rosb_match_checker.
// Depends on rosb_pkg, rosb_stream_if, the block and rosb_match_checker.
`timescale 1ns / 1ps

module tb_relative_offset_byte_search;
    import rosb_pkg::*;

    localparam int CYCLE_LIMIT   = 100000;
    localparam int IDLE_PCT      = 31;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_ROUNDS = 16;
    localparam int ROUND_BYTES   = 100;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    int unsigned          outstanding;
    int unsigned          fail_total;
    int unsigned          cycle_count  = 0;
    logic                 steady       = 1'b0;
    logic                 hold_request = 1'b0;
    needle_t              needle_now;
    int                   span_now;
    logic [BYTE_W-1:0]    byte_plan[$];

    rosb_stream_if #(.payload_t(in_word_t))  data_ch ();
    rosb_stream_if #(.payload_t(out_word_t)) result_ch ();

    relative_offset_byte_search i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .data_ch   (data_ch),
        .result_ch (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rosb_match_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (data_ch.valid),
        .byte_ready   (data_ch.ready),
        .byte_word    (data_ch.payload),
        .result_valid (result_ch.valid),
        .result_ready (result_ch.ready),
        .result_word  (result_ch.payload),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .outstanding  (outstanding),
        .fail_total   (fail_total)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial
    begin
        int hold_left;
        hold_left = 0;
        result_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic write_reg(input cfg_reg_t which, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= which;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic load_needle(input needle_t pattern, input logic [NLEN_W-1:0] len);
        write_reg(CFG_NEEDLE_LOW, pattern[7:0]);
        write_reg(CFG_NEEDLE_HIGH, pattern[15:8]);
        write_reg(CFG_NEEDLE_LEN, CFG_W'(len));
        cfg_we <= 1'b0;
        needle_now = pattern;
        span_now = (len > MAX_NEEDLE_DEF) ? MAX_NEEDLE_DEF : int'(len);
    endtask

    // Queue a window that lines up with the needle under the given offset.
    task automatic plan_run(input logic [BYTE_W-1:0] offset);
        for (int k = 0; k < span_now; k++)
            byte_plan.push_back(needle_now[k] - offset);
    endtask

    task automatic send_plan();
        while (byte_plan.size() > 0)
        begin
            if (!steady && $urandom_range(99) < IDLE_PCT)
            begin
                data_ch.valid <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                data_ch.valid <= 1'b1;
                data_ch.payload.data_byte <= byte_plan.pop_front();
                do @(posedge clk); while (!data_ch.ready);
            end
        end
        data_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        do @(posedge clk); while (outstanding != 0);
    endtask

    initial
    begin
        needle_t           pat;
        logic [NLEN_W-1:0] len;
        logic [BYTE_W-1:0] offset;
        int                first;
        int                idx;
        rst_n                     <= 1'b0;
        cfg_we                    <= 1'b0;
        cfg_index                 <= CFG_NEEDLE_LOW;
        cfg_data                  <= '0;
        data_ch.valid             <= 1'b0;
        data_ch.payload.data_byte <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Short stream first: the leading bytes cannot hold a whole window.
        pat = '0;
        pat[0] = 8'hff;
        pat[1] = 8'h00;
        pat[2] = 8'h80;
        load_needle(pat, 5'd3);
        plan_run(8'd5);
        plan_run(SHIFT_LIMIT);
        plan_run(8'd0);
        send_plan();
        drain();

        // Reset-like needle: every byte except one off by 255 matches.
        load_needle('0, 5'd1);
        byte_plan = '{8'h00, 8'hff, 8'h01, 8'h80};
        send_plan();
        drain();

        // Largest offset that still counts.
        load_needle('1, 5'd2);
        plan_run(8'd254);
        send_plan();
        drain();

        // Zero length never matches.
        load_needle('0, 5'd0);
        byte_plan = '{8'h00, 8'hff};
        send_plan();
        drain();

        for (int r = 0; r < RANDOM_ROUNDS; r++)
        begin
            case (r)
                0:       pat = '0;
                1:       pat = '1;
                default: pat = {$urandom(), $urandom(), $urandom(), $urandom()};
            endcase
            case (r)
                0:       len = 5'd16;
                1:       len = 5'd31;
                2:       len = 5'd17;
                3:       len = 5'd0;
                4:       len = 5'd1;
                default: len = ($urandom_range(99) < 85) ? NLEN_W'($urandom_range(1, 16))
                                                         : NLEN_W'($urandom_range(0, 31));
            endcase
            load_needle(pat, len);
            steady = (r == 5);
            if (r == 7)
                hold_request = 1'b1;
            while (byte_plan.size() < ROUND_BYTES)
            begin
                if (span_now > 0 && $urandom_range(99) < 70)
                begin
                    offset = ($urandom_range(9) == 0) ? SHIFT_LIMIT
                                                      : BYTE_W'($urandom_range(0, 255));
                    first = byte_plan.size();
                    plan_run(offset);
                    // break the run with a single flipped bit now and then
                    if ($urandom_range(99) < 15)
                    begin
                        idx = first + $urandom_range(span_now - 1);
                        byte_plan[idx] = byte_plan[idx] ^ BYTE_W'(1 << $urandom_range(7));
                    end
                end
                else
                    repeat ($urandom_range(1, 8)) byte_plan.push_back(BYTE_W'($urandom()));
            end
            send_plan();
            drain();
            steady = 1'b0;
        end

        repeat (4) @(posedge clk);
        if (fail_total == 0 && outstanding == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
